FILE: hdl/utf8d_pkg.sv
// UTF-8 stream decoder: shared types and constants.
// Used by utf8d_decode, utf8d_emit and utf8_stream_decoder; no dependencies.
`default_nettype none

package utf8d_pkg;

	localparam int CP_W = 21;

	// replacement code after reset: '?'
	localparam logic [CP_W-1:0] REPL_RESET = 21'd63;

	// lead and continuation byte prefixes
	localparam logic [1:0] CONT_PFX  = 2'b10;
	localparam logic [2:0] LEAD2_PFX = 3'b110;
	localparam logic [3:0] LEAD3_PFX = 4'b1110;
	localparam logic [4:0] LEAD4_PFX = 5'b11110;

	// continuations needed by each lead
	localparam logic [1:0] NEED_NONE = 2'd0;
	localparam logic [1:0] NEED_TWO  = 2'd1;
	localparam logic [1:0] NEED_THR  = 2'd2;
	localparam logic [1:0] NEED_FOUR = 2'd3;

	// work for one byte: rep_n replacements, then optionally one decoded value
	typedef struct packed {
		logic [2:0]      rep_n;
		logic            has_val;
		logic [CP_W-1:0] val;
		logic            eot;
	} utf8d_job_t;

endpackage

`default_nettype wire

FILE: hdl/utf8d_decode.sv
// UTF-8 byte decoder: sequence state registers and the per-byte decode.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_decode
	import utf8d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_text,
	input  wire logic        commit,
	output utf8d_job_t       job
);

	logic [CP_W-1:0] part_q, nxt_part;
	logic [1:0]      need_q, nxt_need;
	logic [1:0]      held_q, nxt_held;
	logic [2:0]      held1;
	logic [2:0]      rep;
	logic [CP_W-1:0] ext;
	logic            fresh;
	logic            opened;

	// decode one byte against the open sequence
	always_comb begin
		job         = '0;
		job.eot     = end_of_text;
		nxt_part    = part_q;
		nxt_need    = need_q;
		nxt_held    = held_q;
		fresh       = 1'b1;
		opened      = 1'b0;
		rep         = 3'd0;
		held1       = {1'b0, held_q} + 3'd1;
		ext         = {part_q[CP_W-7:0], text_byte[5:0]};

		if (need_q != NEED_NONE) begin
			if (text_byte[7:6] == CONT_PFX) begin
				fresh = 1'b0;
				if (held1 >= {1'b0, need_q}) begin
					// sequence complete
					job.has_val = 1'b1;
					job.val     = ext;
					nxt_part    = '0;
					nxt_need    = NEED_NONE;
					nxt_held    = 2'd0;
				end else if (end_of_text) begin
					// text ends mid-sequence: lead and all continuations replaced
					rep      = held1 + 3'd1;
					nxt_part = '0;
					nxt_need = NEED_NONE;
					nxt_held = 2'd0;
				end else begin
					nxt_part = ext;
					nxt_held = held1[1:0];
				end
			end else begin
				// broken sequence: flush lead and held bytes, reparse this one
				rep = {1'b0, held_q} + 3'd1;
			end
		end

		if (fresh) begin
			nxt_part = '0;
			nxt_need = NEED_NONE;
			nxt_held = 2'd0;
			if (!text_byte[7]) begin
				job.has_val = 1'b1;
				job.val     = {13'd0, text_byte};
			end else if (text_byte[7:5] == LEAD2_PFX) begin
				nxt_need = NEED_TWO;
				nxt_part = {16'd0, text_byte[4:0]};
				opened   = 1'b1;
			end else if (text_byte[7:4] == LEAD3_PFX) begin
				nxt_need = NEED_THR;
				nxt_part = {17'd0, text_byte[3:0]};
				opened   = 1'b1;
			end else if (text_byte[7:3] == LEAD4_PFX) begin
				nxt_need = NEED_FOUR;
				nxt_part = {18'd0, text_byte[2:0]};
				opened   = 1'b1;
			end else begin
				// stray continuation or F8..FF
				rep = rep + 3'd1;
			end
			if (opened && end_of_text) begin
				rep      = rep + 3'd1;
				nxt_part = '0;
				nxt_need = NEED_NONE;
			end
		end

		job.rep_n = rep;
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			need_q <= NEED_NONE;
			held_q <= 2'd0;
		end else if (commit) begin
			part_q <= nxt_part;
			need_q <= nxt_need;
			held_q <= nxt_held;
		end
	end

`ifndef SYNTHESIS
	a_held_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q != NEED_NONE) |-> (held_q < need_q))
		else $error("held continuations reached the needed count");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && end_of_text) |=> (need_q == NEED_NONE))
		else $error("sequence left open after end of text");

	a_job_bound: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (({1'b0, job.rep_n} + {3'd0, job.has_val}) <= 4'd4))
		else $error("more than four results for one byte");
`endif

endmodule

`default_nettype wire

FILE: hdl/utf8d_emit.sv
// UTF-8 decoder result stage: holds one byte's job and issues its results.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_emit
	import utf8d_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire utf8d_job_t      job_in,
	input  wire logic [CP_W-1:0] repl_code,
	output logic                 free,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [CP_W-1:0]      code_point,
	output logic                 replaced,
	output logic                 run_last,
	output logic                 text_done
);

	utf8d_job_t  job_s2;
	logic        valid_s2;
	logic [2:0]  idx_s2;
	logic [2:0]  total;
	logic        last;
	logic        done;

	// result selection
	always_comb begin
		total      = job_s2.rep_n + {2'b00, job_s2.has_val};
		last       = (idx_s2 + 3'd1) == total;
		replaced   = idx_s2 < job_s2.rep_n;
		code_point = replaced ? repl_code : job_s2.val;
		run_last   = last;
		text_done  = last && job_s2.eot;
		out_valid  = valid_s2;
		done       = valid_s2 && out_ready && last;
		free       = !valid_s2 || done;
	end

	// control: valid and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 3'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 3'd0;
		end else if (done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && out_ready) begin
			idx_s2 <= idx_s2 + 3'd1;
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (load) begin
			job_s2 <= job_in;
		end
	end

`ifndef SYNTHESIS
	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (total != 3'd0 && total <= 3'd4))
		else $error("result stage holds an empty or oversized job");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 < total))
		else $error("result index beyond job");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_ready && !last && !load) |=> (idx_s2 == $past(idx_s2) + 3'd1))
		else $error("result index did not advance");
`endif

endmodule

`default_nettype wire

FILE: hdl/utf8_stream_decoder.sv
// Path: a byte is registered and decoded; one with results then waits for the free result stage.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready
// is high; a byte giving n results holds the result stage until all n are taken (n at most four).
// Reset (arst_n low): no open sequence, pipeline empty, replacement code '?'.
// Top level; depends on utf8d_pkg, utf8d_decode and utf8d_emit.
`default_nettype none

module utf8_stream_decoder
	import utf8d_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [CP_W-1:0] cfg_wr_data,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      text_byte,
	input  wire logic            end_of_text,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [CP_W-1:0]      code_point,
	output logic                 replaced,
	output logic                 run_last,
	output logic                 text_done
);

	logic [CP_W-1:0] repl_q;
	logic            valid_s1;
	logic [7:0]      text_byte_s1;
	logic            end_of_text_s1;
	utf8d_job_t      job;
	logic            job_empty;
	logic            emit_free;
	logic            adv_s1;

	// replacement code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_wr_en) begin
			repl_q <= cfg_wr_data;
		end
	end

	// silent bytes retire at once; others wait for the result stage
	always_comb begin
		job_empty = (job.rep_n == 3'd0) && !job.has_val;
		adv_s1    = valid_s1 && (job_empty || emit_free);
		in_ready  = !valid_s1 || adv_s1;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_byte_s1   <= text_byte;
			end_of_text_s1 <= end_of_text;
		end
	end

	utf8d_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte_s1),
		.end_of_text (end_of_text_s1),
		.commit      (adv_s1),
		.job         (job)
	);

	utf8d_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s1 && !job_empty),
		.job_in     (job),
		.repl_code  (repl_q),
		.free       (emit_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.replaced   (replaced),
		.run_last   (run_last),
		.text_done  (text_done)
	);

endmodule

`default_nettype wire
